### rtl/gillespie_direct_step_top_defines.svh
// Assertion helpers shared by the queue and core RTL files of this block.
`ifndef GILLESPIE_DIRECT_STEP_TOP_DEFINES_SVH
`define GILLESPIE_DIRECT_STEP_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define GDS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define GDS_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/gds_pkg.sv
package gds_pkg;

  localparam int TIME_BITS          = 48;
  localparam int RATE_BITS          = 40;
  localparam int RATE_FRAC_BITS     = 24;
  localparam int ICNT_BITS          = 20;
  localparam int RAND_BITS          = 32;
  localparam int PROP_BITS          = 64;
  localparam int NEGLN_BITS         = 38;
  localparam int COUNT_BITS_DEF     = 20;
  localparam int TIME_FRAC_BITS_DEF = 32;
  localparam int CFG_ADDR_BITS      = 6;
  localparam int CFG_DATA_BITS      = 64;

  localparam logic [RAND_BITS-1:0] LN2_Q32  = 32'd2977044472;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [RATE_BITS-1:0] RST_RATE_DIMER     = 40'd251658;
  localparam logic [RATE_BITS-1:0] RST_RATE_TRIMER    = 40'd280;
  localparam logic [RATE_BITS-1:0] RST_RATE_SOURCE    = 40'd3355443200;
  localparam logic [RATE_BITS-1:0] RST_RATE_DECAY     = 40'd58720256;
  localparam logic [TIME_BITS-1:0] RST_START_TIME     = 48'd0;
  localparam logic [TIME_BITS-1:0] RST_END_TIME       = 48'd42949672960;
  localparam logic [TIME_BITS-1:0] RST_OUTPUT_IVL     = 48'd42949673;
  localparam logic [ICNT_BITS-1:0] RST_INITIAL_COUNT  = 20'd250;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef enum logic [1:0] {
    RK_INITIAL  = 2'd0,
    RK_INTERVAL = 2'd1,
    RK_FINAL    = 2'd2,
    RK_STALL    = 2'd3
  } rec_kind_t;

  typedef enum logic [2:0] {
    REG_RATE_DIMER    = 3'd0,
    REG_RATE_TRIMER   = 3'd1,
    REG_RATE_SOURCE   = 3'd2,
    REG_RATE_DECAY    = 3'd3,
    REG_START_TIME    = 3'd4,
    REG_END_TIME      = 3'd5,
    REG_OUTPUT_IVL    = 3'd6,
    REG_INITIAL_COUNT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_BITS-1:0] rate_dimer;
    logic [RATE_BITS-1:0] rate_trimer;
    logic [RATE_BITS-1:0] rate_source;
    logic [RATE_BITS-1:0] rate_decay;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic [TIME_BITS-1:0] output_interval;
    logic [ICNT_BITS-1:0] initial_count;
  } cfg_t;

  function automatic logic [PROP_BITS-1:0] add_sat64(input logic [PROP_BITS-1:0] a,
                                                      input logic [PROP_BITS-1:0] b);
    logic [PROP_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PROP_BITS] ? {PROP_BITS{1'b1}} : s[PROP_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] time_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

endpackage

### rtl/gds_mul.sv
module gds_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * 64'(b);
    end
  end

endmodule

### rtl/gds_outq.sv
`include "gillespie_direct_step_top_defines.svh"

module gds_outq #(
  parameter int W = 71
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `GDS_CHECK(a_cnt_bound, cnt_r <= 2'd2, "output queue count out of range")
  `GDS_CHECK_NEXT(a_cnt_grow, do_push && !do_pop, cnt_r == $past(cnt_r) + 2'd1, "queue lost a push")
  `GDS_CHECK_NEXT(a_data_kept, do_push, mem_r[$past(wp_r)] == $past(push_data), "queue data not stored")

endmodule

### rtl/gds_core.sv
`include "gillespie_direct_step_top_defines.svh"

module gds_core #(
  parameter int COUNT_BITS     = gds_pkg::COUNT_BITS_DEF,
  parameter int TIME_FRAC_BITS = gds_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  gds_pkg::cfg_t                               cfg,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic                                        in_kind,
  input  logic [gds_pkg::RAND_BITS-1:0]               in_rand_time,
  input  logic [gds_pkg::RAND_BITS-1:0]               in_rand_pick,
  output logic                                        push_valid,
  input  logic                                        push_ready,
  output logic [2+gds_pkg::TIME_BITS+COUNT_BITS:0]    push_data
);

  import gds_pkg::*;

  localparam int DIV_SHIFT = (TIME_FRAC_BITS > RAND_BITS) ? TIME_FRAC_BITS - RAND_BITS : 0;
  localparam int Q_SHIFT   = (TIME_FRAC_BITS < RAND_BITS) ? RAND_BITS - TIME_FRAC_BITS : 0;
  localparam int DIV_BITS  = NEGLN_BITS + RATE_FRAC_BITS + DIV_SHIFT;
  localparam int DCNT_BITS = $clog2(DIV_BITS);
  localparam int RW        = 3 + TIME_BITS + COUNT_BITS;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL    = 9'b000000010,
    ST_SUM    = 9'b000000100,
    ST_NORM   = 9'b000001000,
    ST_LOGSQ  = 9'b000010000,
    ST_LOGUPD = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_UPDATE = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    OP_PAIR   = 3'd0,
    OP_DIMER  = 3'd1,
    OP_TRIPLE = 3'd2,
    OP_TRIMER = 3'd3,
    OP_DECAY  = 3'd4,
    OP_TARGET = 3'd5,
    OP_LOGE   = 3'd6
  } op_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [COUNT_BITS-1:0]  x_r, x_nxt;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic [TIME_BITS-1:0]   nout_r, nout_nxt;
  logic                   run_r, run_nxt;
  logic [RAND_BITS-1:0]   r1_r, r1_nxt, r2_r, r2_nxt;
  logic [2:0]             k_r, k_nxt;
  logic [127:0]           acc_r, acc_nxt;
  logic [PROP_BITS-1:0]   pair_r, pair_nxt, triple_r, triple_nxt;
  logic [PROP_BITS-1:0]   prop0_r, prop0_nxt, prop1_r, prop1_nxt, prop3_r, prop3_nxt;
  logic [PROP_BITS-1:0]   cum1_r, cum1_nxt, cum2_r, cum2_nxt, cum3_r, cum3_nxt;
  logic [PROP_BITS-1:0]   tgt_r, tgt_nxt;
  logic [1:0]             sstep_r, sstep_nxt;
  logic [31:0]            m_r, m_nxt, f_r, f_nxt;
  logic [4:0]             sh_r, sh_nxt, lcnt_r, lcnt_nxt;
  logic [PROP_BITS-1:0]   nl_r, nl_nxt;
  logic [DIV_BITS-1:0]    dv_r, dv_nxt, quo_r, quo_nxt;
  logic [PROP_BITS-1:0]   rem_r, rem_nxt;
  logic [DCNT_BITS-1:0]   dcnt_r, dcnt_nxt;
  logic [TIME_BITS-1:0]   tau_r, tau_nxt;
  logic [RW-1:0]          rec0_r, rec0_nxt, rec1_r, rec1_nxt;
  logic                   pend_r, pend_nxt;

  logic [PROP_BITS-1:0]   opa, opb, xw, sat_res, mid_res;
  logic [31:0]            mul_a, mul_b;
  logic                   mul_en;
  logic [63:0]            prod;
  logic [1:0]             kp;
  logic [127:0]           pp;

  gds_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  assign xw = PROP_BITS'(x_r);

  always_comb begin
    case (op_r)
      OP_PAIR:   begin opa = xw;       opb = xw - 64'd1; end
      OP_DIMER:  begin opa = pair_r;   opb = PROP_BITS'(cfg.rate_dimer); end
      OP_TRIPLE: begin opa = pair_r;   opb = xw - 64'd2; end
      OP_TRIMER: begin opa = triple_r; opb = PROP_BITS'(cfg.rate_trimer); end
      OP_DECAY:  begin opa = xw;       opb = PROP_BITS'(cfg.rate_decay); end
      OP_TARGET: begin opa = cum3_r;   opb = PROP_BITS'(r2_r); end
      OP_LOGE:   begin opa = nl_r;     opb = PROP_BITS'(LN2_Q32); end
      default:   begin opa = '0;       opb = '0; end
    endcase
  end

  // A 64 by 64 product is built from four 32 by 32 partial products.
  always_comb begin
    if (state_r == ST_LOGSQ) begin
      mul_a = m_r;
      mul_b = m_r;
    end else begin
      mul_a = k_r[1] ? opa[63:32] : opa[31:0];
      mul_b = k_r[0] ? opb[63:32] : opb[31:0];
    end
    mul_en = ((state_r == ST_MUL) && (k_r != 3'd4)) || (state_r == ST_LOGSQ);
  end

  always_comb begin
    kp = 2'(k_r - 3'd1);
    case (kp)
      2'd0:    pp = {64'b0, prod};
      2'd1:    pp = {32'b0, prod, 32'b0};
      2'd2:    pp = {32'b0, prod, 32'b0};
      2'd3:    pp = {prod, 64'b0};
      default: pp = '0;
    endcase
    acc_nxt = (k_r == 3'd0) ? '0 : acc_r + pp;
    sat_res = (|acc_nxt[127:64]) ? {PROP_BITS{1'b1}} : acc_nxt[63:0];
    mid_res = acc_nxt[95:32];
  end

  always_comb begin
    logic                   fin, ivl, c0, c1, c2, inc, ge, is_start;
    logic [TIME_BITS-1:0]   t_next;
    logic [COUNT_BITS-1:0]  x_new, x_init;
    logic [32:0]            sq;
    logic [31:0]            f_new;
    logic [PROP_BITS:0]     rem2;
    logic [DIV_BITS-1:0]    qs;

    state_nxt  = state_r;   op_nxt    = op_r;    x_nxt    = x_r;
    time_nxt   = time_r;    nout_nxt  = nout_r;  run_nxt  = run_r;
    r1_nxt     = r1_r;      r2_nxt    = r2_r;    k_nxt    = k_r;
    pair_nxt   = pair_r;    triple_nxt = triple_r;
    prop0_nxt  = prop0_r;   prop1_nxt = prop1_r; prop3_nxt = prop3_r;
    cum1_nxt   = cum1_r;    cum2_nxt  = cum2_r;  cum3_nxt = cum3_r;
    tgt_nxt    = tgt_r;     sstep_nxt = sstep_r;
    m_nxt      = m_r;       f_nxt     = f_r;     sh_nxt   = sh_r;
    lcnt_nxt   = lcnt_r;    nl_nxt    = nl_r;
    dv_nxt     = dv_r;      quo_nxt   = quo_r;   rem_nxt  = rem_r;
    dcnt_nxt   = dcnt_r;    tau_nxt   = tau_r;
    rec0_nxt   = rec0_r;    rec1_nxt  = rec1_r;  pend_nxt = pend_r;

    in_ready   = (state_r == ST_IDLE);
    push_valid = (state_r == ST_EMIT);
    push_data  = rec0_r;

    x_init   = COUNT_BITS'(cfg.initial_count);
    is_start = (in_kind == KIND_START);
    fin = 1'b0; ivl = 1'b0; c0 = 1'b0; c1 = 1'b0; c2 = 1'b0; inc = 1'b0; ge = 1'b0;
    t_next = '0; x_new = x_r; sq = '0; f_new = f_r; rem2 = '0; qs = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (is_start) begin
            fin       = (cfg.start_time >= cfg.end_time);
            x_nxt     = x_init;
            time_nxt  = cfg.start_time;
            nout_nxt  = time_add(cfg.start_time, cfg.output_interval);
            run_nxt   = !fin;
            rec0_nxt  = {!fin, x_init, cfg.start_time, RK_INITIAL};
            rec1_nxt  = {1'b1, x_init, cfg.start_time, RK_FINAL};
            pend_nxt  = fin;
            state_nxt = ST_EMIT;
          end else if (run_r) begin
            if (time_r >= cfg.end_time) begin
              run_nxt   = 1'b0;
              rec0_nxt  = {1'b1, x_r, time_r, RK_FINAL};
              pend_nxt  = 1'b0;
              state_nxt = ST_EMIT;
            end else begin
              r1_nxt    = in_rand_time;
              r2_nxt    = in_rand_pick;
              op_nxt    = OP_PAIR;
              k_nxt     = 3'd0;
              state_nxt = ST_MUL;
            end
          end
        end
      end

      ST_MUL: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd4) begin
          k_nxt = 3'd0;
          case (op_r)
            OP_PAIR:   begin pair_nxt = sat_res; op_nxt = OP_DIMER; end
            OP_DIMER: begin
              prop0_nxt = (x_r < COUNT_BITS'(2)) ? '0 : sat_res;
              op_nxt    = OP_TRIPLE;
            end
            OP_TRIPLE: begin triple_nxt = sat_res; op_nxt = OP_TRIMER; end
            OP_TRIMER: begin
              prop1_nxt = (x_r < COUNT_BITS'(3)) ? '0 : sat_res;
              op_nxt    = OP_DECAY;
            end
            OP_DECAY: begin
              prop3_nxt = sat_res;
              sstep_nxt = 2'd0;
              state_nxt = ST_SUM;
            end
            OP_TARGET: begin
              tgt_nxt = mid_res;
              if (r1_r == '0) begin
                tau_nxt   = TIME_MAX;
                state_nxt = ST_UPDATE;
              end else begin
                m_nxt     = r1_r;
                sh_nxt    = 5'd0;
                state_nxt = ST_NORM;
              end
            end
            OP_LOGE: begin
              // Dividend is -ln(r1) scaled to the rate format, then widened for extra bits.
              dv_nxt    = DIV_BITS'({mid_res[NEGLN_BITS-1:0], {RATE_FRAC_BITS{1'b0}}})
                          << DIV_SHIFT;
              rem_nxt   = '0;
              quo_nxt   = '0;
              dcnt_nxt  = '0;
              state_nxt = ST_DIV;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SUM: begin
        sstep_nxt = sstep_r + 2'd1;
        case (sstep_r)
          2'd0: cum1_nxt = add_sat64(prop0_r, prop1_r);
          2'd1: cum2_nxt = add_sat64(cum1_r, PROP_BITS'(cfg.rate_source));
          default: begin
            cum3_nxt = add_sat64(cum2_r, prop3_r);
            if (cum3_nxt == '0) begin
              run_nxt   = 1'b0;
              rec0_nxt  = {1'b1, x_r, time_r, RK_STALL};
              pend_nxt  = 1'b0;
              state_nxt = ST_EMIT;
            end else begin
              op_nxt    = OP_TARGET;
              k_nxt     = 3'd0;
              state_nxt = ST_MUL;
            end
          end
        endcase
      end

      ST_NORM: begin
        if (m_r[31]) begin
          f_nxt     = '0;
          lcnt_nxt  = 5'd31;
          state_nxt = ST_LOGSQ;
        end else begin
          m_nxt  = {m_r[30:0], 1'b0};
          sh_nxt = sh_r + 5'd1;
        end
      end

      ST_LOGSQ: state_nxt = ST_LOGUPD;

      ST_LOGUPD: begin
        // One fraction bit of log2 per squaring of the mantissa.
        sq    = prod[63:31];
        f_new = f_r | (sq[32] ? (32'd1 << lcnt_r) : 32'd0);
        m_nxt = sq[32] ? sq[32:1] : sq[31:0];
        f_nxt = f_new;
        if (lcnt_r == 5'd0) begin
          nl_nxt    = {26'b0, {1'b0, sh_r} + 6'd1, 32'b0} - {32'b0, f_new};
          op_nxt    = OP_LOGE;
          k_nxt     = 3'd0;
          state_nxt = ST_MUL;
        end else begin
          lcnt_nxt  = lcnt_r - 5'd1;
          state_nxt = ST_LOGSQ;
        end
      end

      ST_DIV: begin
        rem2     = {rem_r, dv_r[DIV_BITS-1]};
        ge       = (rem2 >= {1'b0, cum3_r});
        rem_nxt  = ge ? PROP_BITS'(rem2 - {1'b0, cum3_r}) : rem2[PROP_BITS-1:0];
        quo_nxt  = {quo_r[DIV_BITS-2:0], ge};
        dv_nxt   = {dv_r[DIV_BITS-2:0], 1'b0};
        dcnt_nxt = dcnt_r + DCNT_BITS'(1);
        if (dcnt_r == DCNT_BITS'(DIV_BITS - 1)) begin
          qs        = quo_nxt >> Q_SHIFT;
          tau_nxt   = (qs > DIV_BITS'(TIME_MAX)) ? TIME_MAX : qs[TIME_BITS-1:0];
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        c0  = (prop0_r > tgt_r);
        c1  = (cum1_r > tgt_r);
        c2  = (cum2_r > tgt_r);
        inc = c0 || (!c1 && c2);
        if (inc) begin
          x_new = (x_r == {COUNT_BITS{1'b1}}) ? x_r : x_r + COUNT_BITS'(1);
        end else begin
          x_new = (x_r == '0) ? x_r : x_r - COUNT_BITS'(1);
        end
        t_next   = time_add(time_r, tau_r);
        ivl      = (t_next > nout_r);
        fin      = (t_next >= cfg.end_time);
        time_nxt = t_next;
        x_nxt    = x_new;
        pend_nxt = 1'b0;
        if (fin) begin
          run_nxt = 1'b0;
        end
        if (ivl) begin
          nout_nxt = time_add(nout_r, cfg.output_interval);
          rec0_nxt = {!fin, x_r, time_r, RK_INTERVAL};
          rec1_nxt = {1'b1, x_new, t_next, RK_FINAL};
          pend_nxt = fin;
        end else if (fin) begin
          rec0_nxt = {1'b1, x_new, t_next, RK_FINAL};
        end
        state_nxt = (ivl || fin) ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        if (push_ready) begin
          if (pend_r) begin
            rec0_nxt = rec1_r;
            pend_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_PAIR;
      run_r   <= 1'b0;
      pend_r  <= 1'b0;
      k_r     <= 3'd0;
      sstep_r <= 2'd0;
      lcnt_r  <= 5'd0;
      dcnt_r  <= '0;
      x_r     <= '0;
      time_r  <= '0;
      nout_r  <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      run_r   <= run_nxt;
      pend_r  <= pend_nxt;
      k_r     <= k_nxt;
      sstep_r <= sstep_nxt;
      lcnt_r  <= lcnt_nxt;
      dcnt_r  <= dcnt_nxt;
      x_r     <= x_nxt;
      time_r  <= time_nxt;
      nout_r  <= nout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r1_r     <= r1_nxt;
    r2_r     <= r2_nxt;
    acc_r    <= acc_nxt;
    pair_r   <= pair_nxt;
    triple_r <= triple_nxt;
    prop0_r  <= prop0_nxt;
    prop1_r  <= prop1_nxt;
    prop3_r  <= prop3_nxt;
    cum1_r   <= cum1_nxt;
    cum2_r   <= cum2_nxt;
    cum3_r   <= cum3_nxt;
    tgt_r    <= tgt_nxt;
    m_r      <= m_nxt;
    f_r      <= f_nxt;
    sh_r     <= sh_nxt;
    nl_r     <= nl_nxt;
    dv_r     <= dv_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    tau_r    <= tau_nxt;
    rec0_r   <= rec0_nxt;
    rec1_r   <= rec1_nxt;
  end

  `GDS_CHECK(a_div_nonzero, (state_r == ST_DIV) |-> (cum3_r != '0), "division by a zero propensity sum")
  `GDS_CHECK(a_mul_cnt, (state_r == ST_MUL) |-> (k_r <= 3'd4), "partial product counter overrun")
  `GDS_CHECK_NEXT(a_time_mono, state_r == ST_UPDATE, time_r >= $past(time_r), "simulation time went backwards")
  `GDS_CHECK(a_end_stops, push_valid && ((rec0_r[1:0] == RK_FINAL) || (rec0_r[1:0] == RK_STALL)) |-> !run_r, "run still active after a closing record")

endmodule

### rtl/gillespie_direct_step_top.sv
// Channel  Direction  Payload
// in_      slave      tuser: kind; tdata: rand_time, rand_pick
// out_     master     tuser: record_kind; tdata: sample_time, sample_count; tlast: last
// cfg_     APB slave  eight registers at byte address 8*i, 64-bit data
//
// A step item computes seven 64-bit products of four partial products each on the shared
// 32 by 32 multiplier, up to 31 normalising shifts, the log squarings and the waiting-time
// divide at one quotient bit per cycle (62 bits at the default time format).
// Reset is synchronous and active low; no run is active after it.
// A two-entry queue holds records, so a stalled result side holds up the next item only once it is full.
module gillespie_direct_step_top #(
  parameter int COUNT_BITS     = gds_pkg::COUNT_BITS_DEF,
  parameter int TIME_FRAC_BITS = gds_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   in_tvalid,
  output logic                                                   in_tready,
  input  logic [63:0]                                            in_tdata,   // rand_time, rand_pick
  input  logic                                                   in_tuser,   // kind
  output logic                                                   out_tvalid,
  input  logic                                                   out_tready,
  output logic [((gds_pkg::TIME_BITS+COUNT_BITS+7)/8)*8-1:0]     out_tdata,  // sample_time, sample_count
  output logic [1:0]                                             out_tuser,  // record_kind
  output logic                                                   out_tlast,
  input  logic                                                   cfg_psel,
  input  logic                                                   cfg_penable,
  input  logic                                                   cfg_pwrite,
  input  logic [gds_pkg::CFG_ADDR_BITS-1:0]                      cfg_paddr,
  input  logic [gds_pkg::CFG_DATA_BITS-1:0]                      cfg_pwdata,
  output logic [gds_pkg::CFG_DATA_BITS-1:0]                      cfg_prdata,
  output logic                                                   cfg_pready
);

  import gds_pkg::*;

  localparam int RW    = 3 + TIME_BITS + COUNT_BITS;
  localparam int OUT_W = ((TIME_BITS + COUNT_BITS + 7) / 8) * 8;

  cfg_t           cfg_r;
  reg_idx_t       idx;
  logic           wr_en;
  logic           push_valid, push_ready;
  logic [RW-1:0]  push_data, pop_data;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_BITS-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_dimer      <= RST_RATE_DIMER;
      cfg_r.rate_trimer     <= RST_RATE_TRIMER;
      cfg_r.rate_source     <= RST_RATE_SOURCE;
      cfg_r.rate_decay      <= RST_RATE_DECAY;
      cfg_r.start_time      <= RST_START_TIME;
      cfg_r.end_time        <= RST_END_TIME;
      cfg_r.output_interval <= RST_OUTPUT_IVL;
      cfg_r.initial_count   <= RST_INITIAL_COUNT;
    end else if (wr_en) begin
      case (idx)
        REG_RATE_DIMER:    cfg_r.rate_dimer      <= cfg_pwdata[RATE_BITS-1:0];
        REG_RATE_TRIMER:   cfg_r.rate_trimer     <= cfg_pwdata[RATE_BITS-1:0];
        REG_RATE_SOURCE:   cfg_r.rate_source     <= cfg_pwdata[RATE_BITS-1:0];
        REG_RATE_DECAY:    cfg_r.rate_decay      <= cfg_pwdata[RATE_BITS-1:0];
        REG_START_TIME:    cfg_r.start_time      <= cfg_pwdata[TIME_BITS-1:0];
        REG_END_TIME:      cfg_r.end_time        <= cfg_pwdata[TIME_BITS-1:0];
        REG_OUTPUT_IVL:    cfg_r.output_interval <= cfg_pwdata[TIME_BITS-1:0];
        REG_INITIAL_COUNT: cfg_r.initial_count   <= cfg_pwdata[ICNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RATE_DIMER:    cfg_prdata = CFG_DATA_BITS'(cfg_r.rate_dimer);
      REG_RATE_TRIMER:   cfg_prdata = CFG_DATA_BITS'(cfg_r.rate_trimer);
      REG_RATE_SOURCE:   cfg_prdata = CFG_DATA_BITS'(cfg_r.rate_source);
      REG_RATE_DECAY:    cfg_prdata = CFG_DATA_BITS'(cfg_r.rate_decay);
      REG_START_TIME:    cfg_prdata = CFG_DATA_BITS'(cfg_r.start_time);
      REG_END_TIME:      cfg_prdata = CFG_DATA_BITS'(cfg_r.end_time);
      REG_OUTPUT_IVL:    cfg_prdata = CFG_DATA_BITS'(cfg_r.output_interval);
      REG_INITIAL_COUNT: cfg_prdata = CFG_DATA_BITS'(cfg_r.initial_count);
      default:           cfg_prdata = '0;
    endcase
  end

  gds_core #(
    .COUNT_BITS     (COUNT_BITS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_kind      (in_tuser),
    .in_rand_time (in_tdata[31:0]),
    .in_rand_pick (in_tdata[63:32]),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  gds_outq #(
    .W (RW)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (pop_data)
  );

  // Record layout from the lowest bit: kind, time, count, last.
  assign out_tuser = pop_data[1:0];
  assign out_tdata = OUT_W'(pop_data[RW-2:2]);
  assign out_tlast = pop_data[RW-1];

endmodule

### test/gillespie_direct_step_top_test.sv
module gillespie_direct_step_top_test;
  import gds_pkg::*;

  localparam int OUT_W = ((TIME_BITS + COUNT_BITS_DEF + 7) / 8) * 8;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [TIME_BITS-1:0] TIME_TOP = {TIME_BITS{1'b1}};
  localparam logic [ICNT_BITS-1:0] COUNT_TOP = {ICNT_BITS{1'b1}};
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct {
    rec_kind_t             kind;
    logic [TIME_BITS-1:0]  t;
    logic [ICNT_BITS-1:0]  cnt;
    logic                  last;
  } sample_t;

  typedef enum logic {ACT_ITEM, ACT_REG} act_t;

  typedef struct {
    act_t        act;
    logic        kind;
    logic [31:0] r1;
    logic [31:0] r2;
    reg_idx_t    idx;
    logic [63:0] val;
    bit          typed;
    int          typed_n;
    sample_t     rec;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;    // rand_time, rand_pick
  logic                  in_tuser = 1'b0;  // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;        // sample_time, sample_count
  logic [1:0]            out_tuser;        // record_kind
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                  cfg_pready;

  gillespie_direct_step_top i_dut (.*);

  always #5 clk = ~clk;

  // Shadow of the block's registers and run state.
  logic [RATE_BITS-1:0] k_dimer, k_trimer, k_source, k_decay;
  logic [TIME_BITS-1:0] t_start, t_end, t_ivl;
  logic [ICNT_BITS-1:0] x_init;
  logic [ICNT_BITS-1:0] pop_count;
  logic [TIME_BITS-1:0] sim_now, next_sample_at;
  logic                 run_active;

  sample_t expected_samples[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 0) ? SAT64 : p[63:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SAT64 : s[63:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] time_sum(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_TOP : s[TIME_BITS-1:0];
  endfunction

  // -ln(r/2^32) in 32 fraction bits: log2 by repeated squaring, then times ln 2.
  function automatic logic [63:0] neg_log(input logic [31:0] r);
    int msb;
    logic [63:0] m, f, nl, hi, lo;
    msb = 31;
    while (msb > 0 && r[msb] == 1'b0) msb--;
    m = ({32'd0, r} << (31 - msb)) & 64'hFFFF_FFFF;
    f = 0;
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        f[i] = 1'b1;
        m = m >> 1;
      end
    end
    nl = (64'(32 - msb) << 32) - f;
    hi = nl >> 32;
    lo = nl & 64'hFFFF_FFFF;
    return hi * LN2_Q32 + ((lo * LN2_Q32) >> 32);
  endfunction

  task automatic predict_transfer(input logic kind, input logic [31:0] r1,
                                  input logic [31:0] r2);
    logic [63:0] x, a0, target, cum, q;
    logic [63:0] prop[4];
    logic [TIME_BITS-1:0] tau, t_next;
    int pick;
    bit ivl;
    if (kind == KIND_START) begin
      pop_count = x_init;
      sim_now = t_start;
      next_sample_at = time_sum(t_start, t_ivl);
      if (sim_now >= t_end) begin
        run_active = 1'b0;
        expected_samples.push_back('{RK_INITIAL, sim_now, pop_count, 1'b0});
        expected_samples.push_back('{RK_FINAL, sim_now, pop_count, 1'b1});
      end else begin
        run_active = 1'b1;
        expected_samples.push_back('{RK_INITIAL, sim_now, pop_count, 1'b1});
      end
      return;
    end
    if (!run_active) return;
    if (sim_now >= t_end) begin
      run_active = 1'b0;
      expected_samples.push_back('{RK_FINAL, sim_now, pop_count, 1'b1});
      return;
    end
    x = 64'(pop_count);
    prop[0] = (x < 2) ? 64'd0 : sat_mul(sat_mul(x, x - 1), 64'(k_dimer));
    prop[1] = (x < 3) ? 64'd0 : sat_mul(sat_mul(sat_mul(x, x - 1), x - 2), 64'(k_trimer));
    prop[2] = 64'(k_source);
    prop[3] = sat_mul(x, 64'(k_decay));
    a0 = sat_add(sat_add(sat_add(prop[0], prop[1]), prop[2]), prop[3]);
    if (a0 == 0) begin
      run_active = 1'b0;
      expected_samples.push_back('{RK_STALL, sim_now, pop_count, 1'b1});
      return;
    end
    if (r1 == 0) begin
      tau = TIME_TOP;
    end else begin
      q = (neg_log(r1) << 24) / a0;
      tau = (q > 64'(TIME_TOP)) ? TIME_TOP : q[TIME_BITS-1:0];
    end
    target = (a0 >> 32) * r2 + (((a0 & 64'hFFFF_FFFF) * r2) >> 32);
    pick = 3;
    cum = 0;
    for (int i = 0; i < 4; i++) begin
      cum = sat_add(cum, prop[i]);
      if (cum > target) begin
        pick = i;
        break;
      end
    end
    t_next = time_sum(sim_now, tau);
    ivl = (t_next > next_sample_at);
    if (ivl) begin
      expected_samples.push_back('{RK_INTERVAL, sim_now, pop_count, 1'b0});
      next_sample_at = time_sum(next_sample_at, t_ivl);
    end
    sim_now = t_next;
    if (pick == 0 || pick == 2) begin
      if (pop_count != COUNT_TOP) pop_count++;
    end else begin
      if (pop_count != 0) pop_count--;
    end
    if (sim_now >= t_end) begin
      run_active = 1'b0;
      expected_samples.push_back('{RK_FINAL, sim_now, pop_count, 1'b1});
    end else if (ivl) begin
      expected_samples[$].last = 1'b1;
    end
  endtask

  // Offers one item and returns at the edge that completes its transfer.
  task automatic offer(input logic kind, input logic [31:0] r1, input logic [31:0] r2,
                       input bit predict);
    logic ok;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {r2, r1};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    if (predict) predict_transfer(kind, r1, r2);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [63:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_RATE_DIMER:    k_dimer = v[RATE_BITS-1:0];
      REG_RATE_TRIMER:   k_trimer = v[RATE_BITS-1:0];
      REG_RATE_SOURCE:   k_source = v[RATE_BITS-1:0];
      REG_RATE_DECAY:    k_decay = v[RATE_BITS-1:0];
      REG_START_TIME:    t_start = v[TIME_BITS-1:0];
      REG_END_TIME:      t_end = v[TIME_BITS-1:0];
      REG_OUTPUT_IVL:    t_ivl = v[TIME_BITS-1:0];
      REG_INITIAL_COUNT: x_init = v[ICNT_BITS-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand40();
    return {24'd0, 8'($urandom), 32'($urandom)};
  endfunction

  // Random register set; the selector forces one extreme now and then.
  task automatic random_setup();
    int sel;
    logic [TIME_BITS-1:0] st;
    sel = $urandom_range(0, 9);
    reg_write(REG_RATE_DIMER, sel == 0 ? rand40() : 64'($urandom_range(0, 4000)));
    reg_write(REG_RATE_TRIMER, sel == 1 ? rand40() : 64'($urandom_range(0, 40)));
    reg_write(REG_RATE_SOURCE, sel == 2 ? rand40() :
              sel == 3 ? 64'd0 : 64'($urandom_range(1, 200)) << 24);
    reg_write(REG_RATE_DECAY, sel == 4 ? rand40() : 64'($urandom_range(0, 1 << 26)));
    st = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 47);
    reg_write(REG_START_TIME, 64'(st));
    reg_write(REG_END_TIME, sel == 5 ? 64'(st >> 1) :
              64'(time_sum(st, 48'($urandom_range(1, 40)) << 30)));
    reg_write(REG_OUTPUT_IVL, sel == 6 ? 64'd0 : 64'($urandom_range(0, 1 << 28)) << 2);
    reg_write(REG_INITIAL_COUNT, sel == 7 ? 64'(COUNT_TOP) :
              sel == 3 ? 64'd0 : 64'($urandom_range(0, 600)));
  endtask

  row_t dir_tab[27] = '{
    '{ACT_ITEM, KIND_STEP, 32'd0, 32'd0, REG_RATE_DIMER, 64'd0, 1, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_START, 32'd0, 32'd0, REG_RATE_DIMER, 64'd0, 1, 1,
      '{RK_INITIAL, 48'd0, 20'd250, 1'b1}},
    '{ACT_ITEM, KIND_STEP, 32'hFFFF_FFFF, 32'h8000_0000, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_STEP, 32'd0, 32'd0, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_STEP, 32'd1, 32'd1, REG_RATE_DIMER, 64'd0, 1, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_END_TIME, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_START, 32'd0, 32'd0, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_END_TIME, 64'hFFFF_FFFF_FFFF, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_OUTPUT_IVL, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_RATE_SOURCE, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_INITIAL_COUNT, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_START, 32'd5, 32'd5, REG_RATE_DIMER, 64'd0, 1, 1,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b1}},
    '{ACT_ITEM, KIND_STEP, 32'd5, 32'd5, REG_RATE_DIMER, 64'd0, 1, 1,
      '{RK_STALL, 48'd0, 20'd0, 1'b1}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_RATE_SOURCE, 64'hFF_FFFF_FFFF, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_INITIAL_COUNT, 64'hF_FFFF, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_RATE_DIMER, 64'hFF_FFFF_FFFF, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_RATE_TRIMER, 64'hFF_FFFF_FFFF, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_RATE_DECAY, 64'hFF_FFFF_FFFF, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_STEP, 32'd1, 32'd0, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_STEP, 32'h8000_0000, 32'h7FFF_FFFF, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_END_TIME, 64'd1, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_STEP, 32'h1234_5678, 32'h9ABC_DEF0, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_REG, KIND_STEP, 32'd0, 32'd0, REG_START_TIME, 64'hFFFF_FFFF_FFFF, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_START, 32'd0, 32'd0, REG_RATE_DIMER, 64'd0, 0, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}},
    '{ACT_ITEM, KIND_STEP, 32'd7, 32'd7, REG_RATE_DIMER, 64'd0, 1, 0,
      '{RK_INITIAL, 48'd0, 20'd0, 1'b0}}
  };

  // Result side: readiness and checking against the oldest expectation.
  initial begin
    logic fire;
    sample_t got, want;
    forever begin
      @(negedge clk);
      fire = rst_n && out_tvalid && out_tready;
      got = '{rec_kind_t'(out_tuser), out_tdata[TIME_BITS-1:0],
              out_tdata[TIME_BITS+ICNT_BITS-1:TIME_BITS], out_tlast};
      @(posedge clk);
      if (fire) begin
        if (expected_samples.size() == 0) begin
          report($sformatf("unexpected transfer kind %0d time %h", got.kind, got.t));
        end else begin
          want = expected_samples.pop_front();
          if (got.kind != want.kind)
            report($sformatf("record_kind %0d, want %0d", got.kind, want.kind));
          if (got.t != want.t)
            report($sformatf("sample_time %h, want %h", got.t, want.t));
          if (got.cnt != want.cnt)
            report($sformatf("sample_count %0d, want %0d", got.cnt, want.cnt));
          if (got.last != want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int sent, steps, keep_n;
    k_dimer = RST_RATE_DIMER;
    k_trimer = RST_RATE_TRIMER;
    k_source = RST_RATE_SOURCE;
    k_decay = RST_RATE_DECAY;
    t_start = RST_START_TIME;
    t_end = RST_END_TIME;
    t_ivl = RST_OUTPUT_IVL;
    x_init = RST_INITIAL_COUNT;
    pop_count = '0;
    sim_now = '0;
    next_sample_at = '0;
    run_active = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].act == ACT_REG) begin
        wait_idle();
        reg_write(dir_tab[i].idx, dir_tab[i].val);
      end else if (dir_tab[i].typed) begin
        offer(dir_tab[i].kind, dir_tab[i].r1, dir_tab[i].r2, 1'b0);
        keep_n = expected_samples.size();
        predict_transfer(dir_tab[i].kind, dir_tab[i].r1, dir_tab[i].r2);
        // The hand-written expectation replaces what the shadow just queued.
        while (expected_samples.size() > keep_n) void'(expected_samples.pop_back());
        if (dir_tab[i].typed_n == 1) expected_samples.push_back(dir_tab[i].rec);
      end else begin
        offer(dir_tab[i].kind, dir_tab[i].r1, dir_tab[i].r2, 1'b1);
      end
    end

    // Back-pressure: a zero interval gives a record per step that advances time while the result side is held.
    wait_idle();
    random_setup();
    reg_write(REG_OUTPUT_IVL, 64'd0);
    reg_write(REG_END_TIME, 64'hFFFF_FFFF_FFFF);
    reg_write(REG_RATE_SOURCE, 64'd1 << 24);
    hold_left = 4000;
    offer(KIND_START, $urandom, $urandom, 1'b1);
    sent = 1;
    repeat (30) begin
      offer(KIND_STEP, $urandom, $urandom, 1'b1);
      sent++;
    end

    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 67;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      random_setup();
      repeat ($urandom_range(1, 3)) begin
        offer(KIND_START, $urandom, $urandom, 1'b1);
        sent++;
        steps = $urandom_range(10, 60);
        repeat (steps) begin
          if ($urandom_range(99) < 5) offer(1'($urandom_range(0, 1)), $urandom, $urandom, 1'b1);
          else offer(KIND_STEP, $urandom, $urandom, 1'b1);
          sent++;
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/gds_pkg.sv
rtl/gds_mul.sv
rtl/gds_outq.sv
rtl/gds_core.sv
rtl/gillespie_direct_step_top.sv
test/gillespie_direct_step_top_test.sv
